// File: hw/rtl/odavg_pkg.sv
// ----------------------------------------------------------------------------
// odavg_pkg
// Shared types and constants for the oversample decimating averager.
// ----------------------------------------------------------------------------
`default_nettype none

package odavg_pkg;

  // decimation rate register
  localparam int unsigned RATE_W = 11;
  localparam logic [RATE_W-1:0] RATE_RESET = 11'd16;

  // m_axis_tuser bit positions
  localparam int unsigned TUSER_W      = 2;
  localparam int unsigned TUSER_NEW    = 0;
  localparam int unsigned TUSER_PRIMED = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } odavg_state_e;

endpackage : odavg_pkg

`default_nettype wire

// File: hw/rtl/odavg_div.sv
// ----------------------------------------------------------------------------
// odavg_div
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module odavg_div #(
  parameter int unsigned DVD_W = 26,
  parameter int unsigned DVS_W = 11
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [DVD_W-1:0] dividend_i,
  input  wire logic        [DVS_W-1:0] divisor_i,
  output      logic                    done_o,
  output      logic signed [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic [DVD_W-1:0]  mag;

  always_comb begin
    mag     = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    // trial subtract: keep the difference when it did not go negative
    if (!diff[DVS_W+1]) begin
      rem_d = diff[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule : odavg_div

`default_nettype wire

// File: hw/rtl/oversample_decimating_averager.sv
// ----------------------------------------------------------------------------
// oversample_decimating_averager
// Accumulate-and-dump decimator returning the running or held mean per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per request in tdata. Each sample gives
//   one result on m_axis: tdata holds the mean, tuser flags a freshly
//   completed block (new_output) and that at least one block has completed
//   (primed). Before the first block completes the mean is sum / count;
//   afterwards it is the held block mean.
//   The rate register is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, which the block does not enforce. Zero acts as
//   one, values above MAX_RATE act as MAX_RATE.
//   Timing: a sample that needs a division (block end, or not yet primed) goes
//   from accept through ST_DIV, where the divider makes one quotient bit per
//   cycle, and ST_DONE to the output register; other samples go straight to
//   ST_DONE. s_axis_tready is low while a sample is in work and returns the
//   cycle after the output register loads. The output register frees the
//   input side: a new sample is taken while a result waits; a finished result
//   stalls only if the previous one is still not taken.
//   Reset clears sum, count, held mean, primed flag and sets rate to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module oversample_decimating_averager #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned MAX_RATE     = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // config
  input  wire logic                                  cfg_we_i,
  input  wire logic [odavg_pkg::RATE_W-1:0]          cfg_wdata_i,
  // sample in
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample
  // result out
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output      logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // mean
  output      logic [odavg_pkg::TUSER_W-1:0]         m_axis_tuser   // new_output, primed
);

  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned CNT_W   = $clog2(MAX_RATE + 1);
  localparam int unsigned SUM_W   = SAMPLE_WIDTH + $clog2(MAX_RATE);

  odavg_pkg::odavg_state_e state_q, state_d;

  logic [odavg_pkg::RATE_W-1:0] rate_q;
  logic [CNT_W-1:0]             rate_eff;
  logic signed [SUM_W-1:0]      sum_q, sum_new;
  logic [CNT_W-1:0]             cnt_q, cnt_new;
  logic signed [SAMPLE_WIDTH-1:0] held_q;
  logic                         primed_q;

  logic signed [SAMPLE_WIDTH-1:0] res_mean_q;
  logic                         res_new_q;
  logic                         res_primed_q;

  logic                         m_valid_q;
  logic [SAMPLE_WIDTH-1:0]      m_mean_q;
  logic                         m_new_q;
  logic                         m_primed_q;

  logic                         accept;
  logic                         block_end;
  logic                         need_div;
  logic                         out_load;
  logic [CNT_W-1:0]             divisor;
  logic                         div_done;
  logic signed [SUM_W-1:0]      quotient;

  always_comb begin
    if (rate_q == '0) begin
      rate_eff = CNT_W'(1);
    end else if (32'(rate_q) > 32'(MAX_RATE)) begin
      rate_eff = CNT_W'(MAX_RATE);
    end else begin
      rate_eff = CNT_W'(rate_q);
    end
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign sum_new   = sum_q + SUM_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  assign cnt_new   = cnt_q + 1'b1;
  // a lowered rate can leave the count above it; the next sample ends the block
  assign block_end = (cnt_new >= rate_eff);
  assign need_div  = block_end || !primed_q;
  assign divisor   = block_end ? rate_eff : cnt_new;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      odavg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = need_div ? odavg_pkg::ST_DIV : odavg_pkg::ST_DONE;
        end
      end
      odavg_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = odavg_pkg::ST_DONE;
        end
      end
      odavg_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = odavg_pkg::ST_IDLE;
        end
      end
      default: state_d = odavg_pkg::ST_IDLE;
    endcase
  end

  odavg_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && need_div),
    .dividend_i (sum_new),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= odavg_pkg::ST_IDLE;
      rate_q   <= odavg_pkg::RATE_RESET;
      sum_q    <= '0;
      cnt_q    <= '0;
      held_q   <= '0;
      primed_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (block_end) begin
          sum_q    <= '0;
          cnt_q    <= '0;
          primed_q <= 1'b1;
        end else begin
          sum_q <= sum_new;
          cnt_q <= cnt_new;
        end
      end
      if (state_q == odavg_pkg::ST_DIV && div_done && res_new_q) begin
        held_q <= quotient[SAMPLE_WIDTH-1:0];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_new_q    <= block_end;
      res_primed_q <= primed_q || block_end;
      if (!need_div) begin
        res_mean_q <= held_q;
      end
    end else if (state_q == odavg_pkg::ST_DIV && div_done) begin
      res_mean_q <= quotient[SAMPLE_WIDTH-1:0];
    end
    if (out_load) begin
      m_mean_q   <= res_mean_q;
      m_new_q    <= res_new_q;
      m_primed_q <= res_primed_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'(m_mean_q);
  always_comb begin
    m_axis_tuser = '0;
    m_axis_tuser[odavg_pkg::TUSER_NEW]    = m_new_q;
    m_axis_tuser[odavg_pkg::TUSER_PRIMED] = m_primed_q;
  end

endmodule : oversample_decimating_averager

`default_nettype wire

// File: hw/rtl/odavg_chk.sv
// ----------------------------------------------------------------------------
// odavg_chk
// Port-level checks for the oversample decimating averager, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module odavg_chk #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 s_axis_tvalid,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  input wire logic [odavg_pkg::TUSER_W-1:0]        m_axis_tuser
);

  logic seen_primed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_primed_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready &&
                 m_axis_tuser[odavg_pkg::TUSER_PRIMED]) begin
      seen_primed_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_new_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      !(m_axis_tuser[odavg_pkg::TUSER_NEW] && !m_axis_tuser[odavg_pkg::TUSER_PRIMED]))
    else $error("new_output without primed");

  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_primed_q |-> m_axis_tuser[odavg_pkg::TUSER_PRIMED])
    else $error("primed dropped");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

endmodule : odavg_chk

bind oversample_decimating_averager odavg_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_odavg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oversample decimating averager: directed table
// then rate phases of random samples, each result checked against the table or a local model.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned SMP_W       = 16;
  localparam int unsigned RATE_W      = odavg_pkg::RATE_W;
  localparam int unsigned RATE_CAP    = 1024;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [SMP_W-1:0] mean;
    logic                    fresh;
    logic                    primed;
  } avg_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_RATE
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int          val;
    bit          typed;
    avg_result_t res;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RATE_W-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [SMP_W-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [SMP_W-1:0]  m_axis_tdata;
  logic [odavg_pkg::TUSER_W-1:0] m_axis_tuser;

  oversample_decimating_averager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // local copy of the averager state
  logic [RATE_W-1:0]       rate_q = odavg_pkg::RATE_RESET;
  longint                  acc_sum = 0;
  int unsigned             acc_cnt = 0;
  logic signed [SMP_W-1:0] hold_mean = '0;
  bit                      primed_q = 1'b0;

  avg_result_t pending_means[$];
  stim_row_t   plan[$];
  avg_result_t want;
  int unsigned mismatches  = 0;
  int unsigned fed_cnt     = 0;
  int unsigned taken_cnt   = 0;
  int unsigned idle_cycles = 0;

  int ph_rate [10] = '{0, 1, 3, 2047, 16, 1024, 5, 0, 0, 0};
  int ph_len  [10] = '{40, 60, 60, 1030, 100, 60, 80, 80, 80, 80};

  function automatic avg_result_t advance_averager(input logic signed [SMP_W-1:0] smp);
    int unsigned eff;
    longint      q;
    avg_result_t r;
    eff = (rate_q == 0) ? 1 : ((rate_q > RATE_CAP) ? RATE_CAP : rate_q);
    acc_sum += smp;
    acc_cnt++;
    r.fresh = 1'b0;
    // a lowered rate may already be met by the carried count
    if (acc_cnt >= eff) begin
      q         = acc_sum / longint'(eff);
      hold_mean = q[SMP_W-1:0];
      acc_sum   = 0;
      acc_cnt   = 0;
      primed_q  = 1'b1;
      r.fresh   = 1'b1;
    end
    if (!primed_q && acc_cnt > 0) begin
      q      = acc_sum / longint'(acc_cnt);
      r.mean = q[SMP_W-1:0];
    end else begin
      r.mean = hold_mean;
    end
    r.primed = primed_q;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input row_kind_e kind, input int val, input bit typed,
                                       input int mean, input bit fresh, input bit primed);
    stim_row_t r;
    r.kind       = kind;
    r.val        = val;
    r.typed      = typed;
    r.res.mean   = 16'(mean);
    r.res.fresh  = fresh;
    r.res.primed = primed;
    return r;
  endfunction

  function automatic logic [SMP_W-1:0] draw_sample(input bit neg_heavy);
    if (neg_heavy && $urandom_range(0, 3) != 0) return 16'h8000;
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_rate(input logic [RATE_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_q = v;
  endtask

  task automatic feed_sample(input logic [SMP_W-1:0] smp, input bit typed,
                             input avg_result_t typed_res);
    int unsigned gap;
    avg_result_t pred;
    gap = ((fed_cnt / 48) % 5 == 4) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_averager(smp);
    pending_means.push_back(typed ? typed_res : pred);
    fed_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: result with none pending: mean %0d tuser %b", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (m_axis_tdata !== want.mean) begin
          $display("%0t: mean expected %0d actual %0d", $time, want.mean,
                   $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tuser[odavg_pkg::TUSER_NEW] !== want.fresh) begin
          $display("%0t: new_output expected %b actual %b", $time, want.fresh,
                   m_axis_tuser[odavg_pkg::TUSER_NEW]);
          mismatches++;
        end
        if (m_axis_tuser[odavg_pkg::TUSER_PRIMED] !== want.primed) begin
          $display("%0t: primed expected %b actual %b", $time, want.primed,
                   m_axis_tuser[odavg_pkg::TUSER_PRIMED]);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles without a config write or an input or output handshake
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: timeout, no progress", $time);
      $display("FAIL oversample_decimating_averager");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, quiet stretches and two long hold-offs
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = ((taken_cnt / 40) % 6 == 5) ? 0 : $urandom_range(0, 8);
      if (taken_cnt == 400 || taken_cnt == 1300) gap = 240;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken_cnt++;
    end
  end

  initial begin
    logic [RATE_W-1:0] rate;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // kind, value, typed, mean, new_output, primed
    plan.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -32768, 1, 0, 0, 0));    // -1/2 truncates to 0
    plan.push_back(mk_row(ROW_SAMPLE, -32768, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 0, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 1, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -1, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 21845, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -21846, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 12345, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -12345, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 100, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -100, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 7, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, -7, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 0, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 32767, 0, 0, 0, 0));    // sixteenth sample closes block
    plan.push_back(mk_row(ROW_RATE, 0, 0, 0, 0, 0));          // zero acts as one
    plan.push_back(mk_row(ROW_SAMPLE, -32768, 1, -32768, 1, 1));
    plan.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 1, 1));
    plan.push_back(mk_row(ROW_RATE, 2047, 0, 0, 0, 0));       // clamps to the cap
    plan.push_back(mk_row(ROW_SAMPLE, 1000, 1, 32767, 0, 1));
    plan.push_back(mk_row(ROW_SAMPLE, 3000, 1, 32767, 0, 1));
    plan.push_back(mk_row(ROW_RATE, 2, 0, 0, 0, 0));          // lowered to the carried count
    plan.push_back(mk_row(ROW_SAMPLE, -2000, 0, 0, 0, 0));
    plan.push_back(mk_row(ROW_SAMPLE, 5, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RATE) write_rate(RATE_W'(plan[i].val));
      else feed_sample(SMP_W'(plan[i].val), plan[i].typed, plan[i].res);
    end

    // phase 3 runs a full capped block of mostly full-scale negative samples
    for (int p = 0; p < 10; p++) begin
      rate = (p < 7) ? RATE_W'(ph_rate[p]) : RATE_W'($urandom_range(1, 40));
      write_rate(rate);
      repeat (ph_len[p]) feed_sample(draw_sample(p == 3), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS oversample_decimating_averager");
    end else begin
      $display("FAIL oversample_decimating_averager");
    end
    $finish;
  end

endmodule
